// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CCHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define CCHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cchr_pkg.sv =====
// Shared widths, constants and types for the horizon line renderer.
// No dependencies; every other file but assert_macros.svh refers to it by scoped names.
package cchr_pkg;

  // field widths
  localparam int ANG_W      = 9;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 5;
  localparam int GLYPH_W    = 8;
  localparam int SP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // column sweep
  localparam int HALF_WIDTH_DEF = 8;
  localparam int CENTER_COL     = 15;
  localparam int MAX_RESULTS    = 32;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

  // line value h = roll*c - pitch*16 + 60; |h| < 8192 for half widths up to 15
  localparam int H_W         = 14;
  localparam int MAG_W       = 13;
  localparam int PITCH_SHIFT = 4;
  localparam int LINE_BIAS   = 60;

  // divide by 120 through a reciprocal, exact for magnitudes below 8192
  localparam int DIV_BASE    = 120;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / DIV_BASE + 1;
  localparam int QUO_W       = 7;
  localparam int REM_W       = 7;

  // sub-cell index = rem*16/120, exact for rem below 120
  localparam int SUB_SHIFT = 11;
  localparam int SUB_MUL   = (16 << SUB_SHIFT) / DIV_BASE + 1;
  localparam int SUB_W     = 4;
  localparam int HT_W      = 8;

  localparam int ROW_BIAS = 3;
  localparam logic [GLYPH_W-SUB_W-1:0] GLYPH_BASE = 4'hC;

  // register reset values
  localparam logic [SP_W-1:0] ROW_SPACING_RST = 3'd4;
  localparam logic            CENTER_DOT_RST  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_SPACING = 2'd0,
    REG_CENTER_DOT  = 2'd1,
    REG_ROLL_REV    = 2'd2,
    REG_PITCH_REV   = 2'd3
  } cfg_reg_t;

  // one sweep slot: a column and whether it is the draw or erase half
  typedef struct packed {
    logic             valid;
    logic             erase;
    logic [COL_W-1:0] col;
    logic             last;
  } slot_t;

  // height in rows (two's complement) and sub-cell index
  typedef struct packed {
    logic [HT_W-1:0]  height;
    logic [SUB_W-1:0] sub;
  } ht_t;

endpackage

// ===== rtl/cchr_height.sv =====
// Line height unit: floor-style split of a line value by 120 into rows and sixteenths.
// Two stages: reciprocal multiply registered, then remainder and sub-cell index.
// Depends on cchr_pkg.
module cchr_height (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [cchr_pkg::H_W-1:0]    line_val,
  output cchr_pkg::ht_t                      ht
);

  localparam int PROD_W = cchr_pkg::MAG_W + $clog2(cchr_pkg::RECIP_MUL + 1);
  localparam int SPRD_W = cchr_pkg::REM_W + $clog2(cchr_pkg::SUB_MUL + 1);

  logic [cchr_pkg::H_W-1:0]   neg_val;
  logic [cchr_pkg::MAG_W-1:0] mag;
  logic [PROD_W-1:0]          prod;
  logic [cchr_pkg::QUO_W-1:0] quo;

  logic [cchr_pkg::MAG_W-1:0] mag_r;
  logic [cchr_pkg::QUO_W-1:0] quo_r;
  logic                       neg_r;

  logic [cchr_pkg::REM_W-1:0] rem;
  logic [SPRD_W-1:0]          sub_prod;
  logic [cchr_pkg::SUB_W-1:0] sub_raw;
  logic [cchr_pkg::HT_W-1:0]  quo_ext;

  // magnitude and quotient by reciprocal
  assign neg_val = -line_val;
  assign mag     = line_val[cchr_pkg::H_W-1] ? neg_val[cchr_pkg::MAG_W-1:0]
                                              : line_val[cchr_pkg::MAG_W-1:0];
  assign prod    = PROD_W'(mag) * PROD_W'(cchr_pkg::RECIP_MUL);
  assign quo     = prod[cchr_pkg::RECIP_SHIFT +: cchr_pkg::QUO_W];

  // hold quotient, magnitude and sign for the second stage
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= mag;
      quo_r <= quo;
      neg_r <= line_val[cchr_pkg::H_W-1];
    end
  end

  // remainder, sixteenths, then for negative values invert both (negate, then lower by one)
  assign rem      = cchr_pkg::REM_W'(mag_r - cchr_pkg::MAG_W'(quo_r)
                                           * cchr_pkg::MAG_W'(cchr_pkg::DIV_BASE));
  assign sub_prod = SPRD_W'(rem) * SPRD_W'(cchr_pkg::SUB_MUL);
  assign sub_raw  = sub_prod[cchr_pkg::SUB_SHIFT +: cchr_pkg::SUB_W];
  assign quo_ext  = cchr_pkg::HT_W'(quo_r);

  assign ht.height = neg_r ? ~quo_ext : quo_ext;
  assign ht.sub    = neg_r ? ~sub_raw : sub_raw;

endmodule

// ===== rtl/cchr_sweep.sv =====
// Input buffer, angle state and column sweep for the horizon renderer.
// Issues two slots per column (draw, then erase) with running line values.
// Depends on cchr_pkg.
module cchr_sweep #(
  parameter int HALF_WIDTH = cchr_pkg::HALF_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cchr_pkg::ANG_W-1:0]   in_roll_deg,
  input  logic signed [cchr_pkg::ANG_W-1:0]   in_pitch_deg,
  input  logic                                roll_rev,
  input  logic                                pitch_rev,
  output logic signed [cchr_pkg::H_W-1:0]     line_new,
  output logic signed [cchr_pkg::H_W-1:0]     line_old,
  output cchr_pkg::slot_t                     slot
);

  localparam logic [cchr_pkg::COL_W-1:0] FIRST_COL =
    cchr_pkg::COL_W'(cchr_pkg::CENTER_COL - HALF_WIDTH);
  localparam logic [cchr_pkg::COL_W-1:0] LAST_COL =
    cchr_pkg::COL_W'(cchr_pkg::CENTER_COL + HALF_WIDTH - 1);
  localparam logic signed [cchr_pkg::H_W-1:0] SPAN = cchr_pkg::H_W'(HALF_WIDTH);
  localparam logic signed [cchr_pkg::ANG_W-1:0] ANG_MIN =
    cchr_pkg::ANG_W'(-(2 ** (cchr_pkg::ANG_W - 1)));
  localparam logic signed [cchr_pkg::ANG_W-1:0] ANG_MAX =
    cchr_pkg::ANG_W'(2 ** (cchr_pkg::ANG_W - 1) - 1);

  // negate when enabled, saturating the most negative angle
  function automatic logic signed [cchr_pkg::ANG_W-1:0] flip(
    input logic signed [cchr_pkg::ANG_W-1:0] a,
    input logic                              en
  );
    logic signed [cchr_pkg::ANG_W-1:0] m;
    m = -a;
    if (!en) return a;
    if (a == ANG_MIN) return ANG_MAX;
    return m;
  endfunction

  // line value at the leftmost column offset
  function automatic logic signed [cchr_pkg::H_W-1:0] line_start(
    input logic signed [cchr_pkg::ANG_W-1:0] roll,
    input logic signed [cchr_pkg::ANG_W-1:0] pitch
  );
    logic signed [cchr_pkg::H_W-1:0] r_x;
    logic signed [cchr_pkg::H_W-1:0] p_x;
    r_x = cchr_pkg::H_W'(roll);
    p_x = cchr_pkg::H_W'(pitch);
    return cchr_pkg::H_W'(cchr_pkg::LINE_BIAS) - r_x * SPAN
           - (p_x <<< cchr_pkg::PITCH_SHIFT);
  endfunction

  logic                              buf_valid_r;
  logic signed [cchr_pkg::ANG_W-1:0] buf_roll_r;
  logic signed [cchr_pkg::ANG_W-1:0] buf_pitch_r;
  logic signed [cchr_pkg::ANG_W-1:0] prev_roll_r;
  logic signed [cchr_pkg::ANG_W-1:0] prev_pitch_r;

  logic                              act_r;
  logic                              erase_r;
  logic [cchr_pkg::COL_W-1:0]        col_r;
  logic signed [cchr_pkg::H_W-1:0]   hn_r;
  logic signed [cchr_pkg::H_W-1:0]   ho_r;
  logic signed [cchr_pkg::ANG_W-1:0] rn_r;
  logic signed [cchr_pkg::ANG_W-1:0] ro_r;

  logic                              last_slot;
  logic                              take;
  logic                              accept;
  logic signed [cchr_pkg::ANG_W-1:0] roll_use;
  logic signed [cchr_pkg::ANG_W-1:0] pitch_use;

  // take the buffered item when the sweep is free or on its final slot
  assign last_slot = act_r && erase_r && (col_r == LAST_COL);
  assign take      = adv && buf_valid_r && (!act_r || last_slot);
  assign in_stall  = buf_valid_r && !take;
  assign accept    = in_valid && !in_stall;

  assign roll_use  = flip(buf_roll_r, roll_rev);
  assign pitch_use = flip(buf_pitch_r, pitch_rev);

  // control state and stored angles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r  <= 1'b0;
      act_r        <= 1'b0;
      prev_roll_r  <= '0;
      prev_pitch_r <= '0;
    end else begin
      if (accept) begin
        buf_valid_r <= 1'b1;
      end else if (take) begin
        buf_valid_r <= 1'b0;
      end
      if (take) begin
        act_r        <= 1'b1;
        prev_roll_r  <= roll_use;
        prev_pitch_r <= pitch_use;
      end else if (adv && last_slot) begin
        act_r <= 1'b0;
      end
    end
  end

  // buffer the beat, then walk columns, stepping line values by the roll
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_roll_r  <= in_roll_deg;
      buf_pitch_r <= in_pitch_deg;
    end
    if (take) begin
      erase_r <= 1'b0;
      col_r   <= FIRST_COL;
      hn_r    <= line_start(roll_use, pitch_use);
      ho_r    <= line_start(prev_roll_r, prev_pitch_r);
      rn_r    <= roll_use;
      ro_r    <= prev_roll_r;
    end else if (adv && act_r) begin
      erase_r <= !erase_r;
      if (erase_r) begin
        col_r <= col_r + cchr_pkg::COL_W'(1);
        hn_r  <= hn_r + cchr_pkg::H_W'(rn_r);
        ho_r  <= ho_r + cchr_pkg::H_W'(ro_r);
      end
    end
  end

  assign line_new   = hn_r;
  assign line_old   = ho_r;
  assign slot.valid = act_r;
  assign slot.erase = erase_r;
  assign slot.col   = col_r;
  assign slot.last  = last_slot;

endmodule

// ===== rtl/cchr_collect.sv =====
// Write selection, one-deep hold for the last flag, and the output register.
// Also produces the pipeline advance enable. Depends on cchr_pkg.
module cchr_collect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cchr_pkg::slot_t                   slot,
  input  cchr_pkg::ht_t                     ht_new,
  input  cchr_pkg::ht_t                     ht_old,
  input  logic [cchr_pkg::SP_W-1:0]         row_spacing,
  input  logic                              center_dot,
  output logic                              adv,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_write_kind,
  output logic [cchr_pkg::ROW_W-1:0]        out_cell_row,
  output logic [cchr_pkg::COL_W-1:0]        out_cell_column,
  output logic [cchr_pkg::GLYPH_W-1:0]      out_glyph_code,
  output logic                              out_last_write
);

  typedef struct packed {
    cchr_pkg::kind_t                 kind;
    logic [cchr_pkg::ROW_W-1:0]      row;
    logic [cchr_pkg::COL_W-1:0]      col;
    logic [cchr_pkg::GLYPH_W-1:0]    glyph;
  } res_t;

  localparam res_t NONE_RES = '{kind: cchr_pkg::KIND_NONE, row: '0, col: '0, glyph: '0};

  cchr_pkg::slot_t                  s1_r;
  logic                             pend_valid_r;
  logic                             pend_closed_r;
  res_t                             pend_r;
  logic [cchr_pkg::CNT_W-1:0]       cnt_r;
  logic                             out_valid_r;
  res_t                             out_r;
  logic                             out_last_r;

  logic signed [cchr_pkg::HT_W-1:0] hn;
  logic signed [cchr_pkg::HT_W-1:0] ho;
  logic signed [cchr_pkg::HT_W-1:0] sp_s;
  logic signed [cchr_pkg::HT_W-1:0] row_ht;
  logic                             centre;
  logic                             new_in;
  logic                             old_in;
  logic                             draw_ok;
  logic                             erase_ok;
  logic                             cand_take;
  logic                             item_end;
  res_t                             cand;

  logic                             out_load;
  logic                             out_last_nxt;
  logic                             pend_clear;
  res_t                             out_nxt;

  assign adv = !out_valid_r || !out_stall;

  // align the slot with the second stage of the height units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else if (adv) begin
      s1_r <= slot;
    end
  end

  // draw and erase rules, centre-dot exception at the two middle columns
  assign hn     = $signed(ht_new.height);
  assign ho     = $signed(ht_old.height);
  assign sp_s   = $signed(cchr_pkg::HT_W'(row_spacing));
  assign centre = center_dot && (s1_r.col == cchr_pkg::COL_W'(cchr_pkg::CENTER_COL - 1) ||
                                 s1_r.col == cchr_pkg::COL_W'(cchr_pkg::CENTER_COL));
  assign new_in   = (hn >= -sp_s) && (hn <= sp_s);
  assign old_in   = (ho >= -sp_s) && (ho <= sp_s);
  assign draw_ok  = !(hn == '0 && centre) && new_in;
  assign erase_ok = !(ho == '0 && centre) && (hn != ho) && old_in;

  assign cand_take = s1_r.valid && (s1_r.erase ? erase_ok : draw_ok)
                     && (cnt_r < cchr_pkg::CNT_W'(cchr_pkg::MAX_RESULTS));
  assign item_end  = s1_r.valid && s1_r.last;

  assign row_ht     = s1_r.erase ? ho : hn;
  assign cand.kind  = s1_r.erase ? cchr_pkg::KIND_ERASE : cchr_pkg::KIND_DRAW;
  assign cand.row   = cchr_pkg::ROW_W'(cchr_pkg::ROW_W'(row_spacing)
                      + cchr_pkg::ROW_W'(cchr_pkg::ROW_BIAS) - row_ht[cchr_pkg::ROW_W-1:0]);
  assign cand.col   = s1_r.col;
  assign cand.glyph = s1_r.erase ? '0 : {cchr_pkg::GLYPH_BASE, ht_new.sub};

  // release the held write once the next one or the item end shows up; an item with no writes gives a none beat
  always_comb begin
    out_load     = 1'b0;
    out_last_nxt = 1'b0;
    pend_clear   = 1'b0;
    out_nxt      = pend_r;
    if (pend_valid_r && pend_closed_r) begin
      out_load     = 1'b1;
      out_last_nxt = 1'b1;
      pend_clear   = 1'b1;
    end else if (pend_valid_r && cand_take) begin
      out_load = 1'b1;
    end else if (item_end && pend_valid_r) begin
      out_load     = 1'b1;
      out_last_nxt = 1'b1;
      pend_clear   = 1'b1;
    end else if (item_end && !cand_take && cnt_r == '0) begin
      out_load     = 1'b1;
      out_last_nxt = 1'b1;
      out_nxt      = NONE_RES;
    end
  end

  // hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r  <= 1'b0;
      pend_closed_r <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else if (adv) begin
      if (cand_take) begin
        pend_valid_r  <= 1'b1;
        pend_closed_r <= item_end;
      end else if (pend_clear) begin
        pend_valid_r <= 1'b0;
      end
      cnt_r       <= item_end ? '0 : cnt_r + cchr_pkg::CNT_W'(cand_take);
      out_valid_r <= out_load;
    end
  end

  // held write and output beat
  always_ff @(posedge clk) begin
    if (adv && cand_take) begin
      pend_r <= cand;
    end
    if (adv && out_load) begin
      out_r      <= out_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_kind  = out_r.kind;
  assign out_cell_row    = out_r.row;
  assign out_cell_column = out_r.col;
  assign out_glyph_code  = out_r.glyph;
  assign out_last_write  = out_last_r;

endmodule

// ===== rtl/char_cell_horizon_renderer.sv =====
// Top level of the character-cell artificial-horizon renderer.
// Holds the configuration registers; uses cchr_pkg, cchr_sweep, cchr_height, cchr_collect.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one beat of roll and pitch in degrees.
//   Result channel (out_valid / out_stall) gives the cell writes for that beat:
//   draws of the new line and erases of cells it left, column by column, the last
//   beat of an item flagged by out_last_write. An item with no writes gives a
//   single beat of kind none.
//   Configuration (cfg_valid / cfg_ready, always ready) writes one register per
//   beat; write it only while no item is in flight.
// Flow:
//   The column sweep issues two slots per column, draw then erase, and a new item
//   enters on the last slot of the previous sweep, so items follow back to back
//   unless the result side stalls; a one-beat buffer holds the next one.
//   A beat passes the buffer, the sweep registers, the height register and the
//   output register; a write can also wait in the one-deep hold before the output.
// Reset clears the stored angles to zero and loads the register defaults.
// A stall on the result side freezes the sweep and the height pipeline; the
// output beat holds until taken.
module char_cell_horizon_renderer #(
  parameter int HALF_WIDTH = cchr_pkg::HALF_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cchr_pkg::ANG_W-1:0]   in_roll_deg,
  input  logic signed [cchr_pkg::ANG_W-1:0]   in_pitch_deg,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_write_kind,
  output logic [cchr_pkg::ROW_W-1:0]          out_cell_row,
  output logic [cchr_pkg::COL_W-1:0]          out_cell_column,
  output logic [cchr_pkg::GLYPH_W-1:0]        out_glyph_code,
  output logic                                out_last_write,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cchr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cchr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [cchr_pkg::SP_W-1:0]       row_spacing_r;
  logic                            center_dot_r;
  logic                            roll_rev_r;
  logic                            pitch_rev_r;

  logic                            adv;
  logic signed [cchr_pkg::H_W-1:0] line_new;
  logic signed [cchr_pkg::H_W-1:0] line_old;
  cchr_pkg::slot_t                 slot;
  cchr_pkg::ht_t                   ht_new;
  cchr_pkg::ht_t                   ht_old;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_spacing_r <= cchr_pkg::ROW_SPACING_RST;
      center_dot_r  <= cchr_pkg::CENTER_DOT_RST;
      roll_rev_r    <= 1'b0;
      pitch_rev_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cchr_pkg::cfg_reg_t'(cfg_index))
        cchr_pkg::REG_ROW_SPACING: row_spacing_r <= cfg_wdata[cchr_pkg::SP_W-1:0];
        cchr_pkg::REG_CENTER_DOT:  center_dot_r  <= cfg_wdata[0];
        cchr_pkg::REG_ROLL_REV:    roll_rev_r    <= cfg_wdata[0];
        cchr_pkg::REG_PITCH_REV:   pitch_rev_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cchr_sweep #(
    .HALF_WIDTH (HALF_WIDTH)
  ) u_sweep (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_roll_deg  (in_roll_deg),
    .in_pitch_deg (in_pitch_deg),
    .roll_rev     (roll_rev_r),
    .pitch_rev    (pitch_rev_r),
    .line_new     (line_new),
    .line_old     (line_old),
    .slot         (slot)
  );

  cchr_height u_ht_new (
    .clk      (clk),
    .adv      (adv),
    .line_val (line_new),
    .ht       (ht_new)
  );

  cchr_height u_ht_old (
    .clk      (clk),
    .adv      (adv),
    .line_val (line_old),
    .ht       (ht_old)
  );

  cchr_collect u_collect (
    .clk             (clk),
    .rst_n           (rst_n),
    .slot            (slot),
    .ht_new          (ht_new),
    .ht_old          (ht_old),
    .row_spacing     (row_spacing_r),
    .center_dot      (center_dot_r),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_write_kind  (out_write_kind),
    .out_cell_row    (out_cell_row),
    .out_cell_column (out_cell_column),
    .out_glyph_code  (out_glyph_code),
    .out_last_write  (out_last_write)
  );

endmodule

// ===== rtl/cchr_checker.sv =====
// Port-level checks for the horizon renderer, attached by bind.
// Depends on cchr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cchr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [cchr_pkg::ANG_W-1:0]   in_roll_deg,
  input logic signed [cchr_pkg::ANG_W-1:0]   in_pitch_deg,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_write_kind,
  input logic [cchr_pkg::ROW_W-1:0]          out_cell_row,
  input logic [cchr_pkg::COL_W-1:0]          out_cell_column,
  input logic [cchr_pkg::GLYPH_W-1:0]        out_glyph_code,
  input logic                                out_last_write,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [cchr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [cchr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // a stalled result beat stays put
  `CCHR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_write_kind) && $stable(out_cell_row) && $stable(out_cell_column) && $stable(out_glyph_code) && $stable(out_last_write), "stalled result beat changed")

  // an empty item gives one beat with zero row, column and glyph that closes it
  `CCHR_ASSERT_NOW(a_none_shape, out_valid && out_write_kind == cchr_pkg::KIND_NONE, out_last_write && out_cell_row == '0 && out_cell_column == '0 && out_glyph_code == '0, "malformed no-write beat")

  // erases write a blank cell
  `CCHR_ASSERT_NOW(a_erase_glyph, out_valid && out_write_kind == cchr_pkg::KIND_ERASE, out_glyph_code == '0, "erase with nonzero glyph")

  // draws use the line glyph block
  `CCHR_ASSERT_NOW(a_draw_glyph, out_valid && out_write_kind == cchr_pkg::KIND_DRAW, out_glyph_code[7:4] == cchr_pkg::GLYPH_BASE, "draw glyph outside line block")

endmodule

bind char_cell_horizon_renderer cchr_checker u_cchr_checker (.*);

// ===== bench/char_cell_horizon_renderer_test.sv =====
// Self-checking bench for char_cell_horizon_renderer: drives roll/pitch beats,
// predicts every cell write and compares the result stream beat by beat.
// Depends on cchr_pkg for port widths, write kinds and register indexes.
`timescale 1ns / 100ps

module char_cell_horizon_renderer_test;

  localparam int HALF_COLS       = cchr_pkg::HALF_WIDTH_DEF;
  localparam int LINE_DIV        = 120;
  localparam int SUB_STEPS       = 16;
  localparam int ANGLE_MAX       = 255;
  localparam logic [7:0] GLYPH_DRAW_BASE = 8'hC0;
  localparam int SETTLE_CYCLES   = 4 * cchr_pkg::HALF_WIDTH_DEF + 3 + 8;
  localparam int LONG_HOLD       = 400;
  localparam int CYCLE_LIMIT     = 800000;

  typedef struct packed {
    logic signed [cchr_pkg::ANG_W-1:0] roll;
    logic signed [cchr_pkg::ANG_W-1:0] pitch;
  } angle_pair_t;

  typedef struct packed {
    cchr_pkg::kind_t              kind;
    logic [cchr_pkg::ROW_W-1:0]   row;
    logic [cchr_pkg::COL_W-1:0]   col;
    logic [cchr_pkg::GLYPH_W-1:0] glyph;
    logic                         last;
  } cell_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [cchr_pkg::ANG_W-1:0] in_roll_deg = '0;
  logic signed [cchr_pkg::ANG_W-1:0] in_pitch_deg = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_write_kind;
  logic [cchr_pkg::ROW_W-1:0] out_cell_row;
  logic [cchr_pkg::COL_W-1:0] out_cell_column;
  logic [cchr_pkg::GLYPH_W-1:0] out_glyph_code;
  logic out_last_write;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cchr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cchr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predicted register copies and stored angles
  logic [cchr_pkg::SP_W-1:0] spacing_q = cchr_pkg::ROW_SPACING_RST;
  logic dot_q = cchr_pkg::CENTER_DOT_RST;
  logic roll_rev_q = 1'b0;
  logic pitch_rev_q = 1'b0;
  int prev_roll = 0;
  int prev_pitch = 0;

  angle_pair_t angles_pending[$];
  cell_write_t cell_writes_due[$];

  int fail_count = 0;
  int items_taken = 0;
  int draws_seen = 0;
  int erases_seen = 0;
  int blank_items = 0;
  int settings_used = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_run = 0;
  int hold_left = 0;
  bit hold_started = 1'b0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int walk_roll = 0;
  int walk_pitch = 0;
  cell_write_t seen;

  char_cell_horizon_renderer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_roll_deg(in_roll_deg),
    .in_pitch_deg(in_pitch_deg),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_write_kind(out_write_kind),
    .out_cell_row(out_cell_row),
    .out_cell_column(out_cell_column),
    .out_glyph_code(out_glyph_code),
    .out_last_write(out_last_write),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Height in rows and sub-cell index at one column; division truncates
  // toward zero, then both drop by one below the line.
  function automatic void line_height(input int roll, input int pitch, input int c,
                                      output int height,
                                      output logic [cchr_pkg::SUB_W-1:0] sub);
    int h;
    int q;
    int s;
    h = roll * c - pitch * SUB_STEPS + cchr_pkg::LINE_BIAS;
    q = h / LINE_DIV;
    s = ((h % LINE_DIV) * SUB_STEPS) / LINE_DIV;
    if (h < 0) begin
      q = q - 1;
      s = s - 1;
    end
    height = q;
    sub = s[cchr_pkg::SUB_W-1:0];
  endfunction

  function automatic int negate_angle(input int a);
    return (-a > ANGLE_MAX) ? ANGLE_MAX : -a;
  endfunction

  // Work out the draw and erase writes for one accepted beat, then store it.
  task automatic render_horizon(input logic signed [cchr_pkg::ANG_W-1:0] roll_in,
                                input logic signed [cchr_pkg::ANG_W-1:0] pitch_in);
    int roll;
    int pitch;
    int sp;
    int c;
    int ht;
    int old_ht;
    int row;
    int col;
    logic [cchr_pkg::SUB_W-1:0] sub;
    logic [cchr_pkg::SUB_W-1:0] old_sub;
    logic centre;
    cell_write_t beat;
    cell_write_t batch[$];
    roll = roll_in;
    pitch = pitch_in;
    if (roll_rev_q) roll = negate_angle(roll);
    if (pitch_rev_q) pitch = negate_angle(pitch);
    sp = spacing_q;
    for (c = -HALF_COLS; c < HALF_COLS; c++) begin
      centre = (c == -1 || c == 0) && dot_q;
      line_height(roll, pitch, c, ht, sub);
      line_height(prev_roll, prev_pitch, c, old_ht, old_sub);
      col = cchr_pkg::CENTER_COL + c;
      if (!(ht == 0 && centre) && ht >= -sp && ht <= sp
          && batch.size() < cchr_pkg::MAX_RESULTS) begin
        row = sp + cchr_pkg::ROW_BIAS - ht;
        beat.kind = cchr_pkg::KIND_DRAW;
        beat.row = row[cchr_pkg::ROW_W-1:0];
        beat.col = col[cchr_pkg::COL_W-1:0];
        beat.glyph = GLYPH_DRAW_BASE + sub;
        beat.last = 1'b0;
        batch.push_back(beat);
      end
      if (!(old_ht == 0 && centre) && ht != old_ht && old_ht >= -sp && old_ht <= sp
          && batch.size() < cchr_pkg::MAX_RESULTS) begin
        row = sp + cchr_pkg::ROW_BIAS - old_ht;
        beat.kind = cchr_pkg::KIND_ERASE;
        beat.row = row[cchr_pkg::ROW_W-1:0];
        beat.col = col[cchr_pkg::COL_W-1:0];
        beat.glyph = '0;
        beat.last = 1'b0;
        batch.push_back(beat);
      end
    end
    if (batch.size() == 0) begin
      beat.kind = cchr_pkg::KIND_NONE;
      beat.row = '0;
      beat.col = '0;
      beat.glyph = '0;
      beat.last = 1'b0;
      batch.push_back(beat);
    end
    foreach (batch[i]) begin
      beat = batch[i];
      beat.last = (i == batch.size() - 1);
      cell_writes_due.push_back(beat);
    end
    prev_roll = roll;
    prev_pitch = pitch;
  endtask

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int pick_idle(input logic quiet, input int long_min, input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(long_min, long_max);
  endfunction

  // Sender: advance on each accepted beat, hold the payload while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        render_horizon(in_roll_deg, in_pitch_deg);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (angles_pending.size() > 0) begin
          in_valid <= 1'b1;
          in_roll_deg <= angles_pending[0].roll;
          in_pitch_deg <= angles_pending[0].pitch;
          void'(angles_pending.pop_front());
          gap_left = pick_idle(calm, 20, 60);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random runs, plus one long hold when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 60) begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b1;
      stall_run = pick_idle(1'b0, 15, 40);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: compare each taken result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cell_writes_due.size() == 0) begin
        $error("unexpected result beat: kind %0d row %0d column %0d glyph %0h",
               out_write_kind, out_cell_row, out_cell_column, out_glyph_code);
        fail_count++;
      end else begin
        seen = cell_writes_due.pop_front();
        check_field("write_kind", seen.kind, out_write_kind);
        check_field("cell_row", seen.row, out_cell_row);
        check_field("cell_column", seen.col, out_cell_column);
        check_field("glyph_code", seen.glyph, out_glyph_code);
        check_field("last_write", seen.last, out_last_write);
        case (seen.kind)
          cchr_pkg::KIND_DRAW:  draws_seen++;
          cchr_pkg::KIND_ERASE: erases_seen++;
          default:              blank_items++;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run: timed out with %0d items queued and %0d results outstanding",
               angles_pending.size(), cell_writes_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input cchr_pkg::cfg_reg_t idx,
                           input logic [cchr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      cchr_pkg::REG_ROW_SPACING: spacing_q = val;
      cchr_pkg::REG_CENTER_DOT:  dot_q = val[0];
      cchr_pkg::REG_ROLL_REV:    roll_rev_q = val[0];
      cchr_pkg::REG_PITCH_REV:   pitch_rev_q = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int sp, input bit dot, input bit rr, input bit pr);
    write_reg(cchr_pkg::REG_ROW_SPACING, sp[cchr_pkg::CFG_DATA_W-1:0]);
    write_reg(cchr_pkg::REG_CENTER_DOT, {2'b00, dot});
    write_reg(cchr_pkg::REG_ROLL_REV, {2'b00, rr});
    write_reg(cchr_pkg::REG_PITCH_REV, {2'b00, pr});
    settings_used++;
  endtask

  // Wait until the sender is empty and every predicted write has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (angles_pending.size() != 0 || in_valid || cell_writes_due.size() != 0);
  endtask

  task automatic push_pair(input int r, input int p);
    angle_pair_t pair;
    pair.roll = r[cchr_pkg::ANG_W-1:0];
    pair.pitch = p[cchr_pkg::ANG_W-1:0];
    angles_pending.push_back(pair);
  endtask

  function automatic int any_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(0, 511);
    if (pick == 1) begin
      case ($urandom_range(0, 3))
        0: return -256;
        1: return ANGLE_MAX;
        2: return -180;
        default: return 180;
      endcase
    end
    if (pick < 5) return int'($urandom_range(0, 40)) - 20;
    return int'($urandom_range(0, 360)) - 180;
  endfunction

  // Mostly smooth flight near level so the line stays on screen, some noise.
  task automatic queue_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        walk_roll = walk_roll + int'($urandom_range(0, 16)) - 8;
        walk_pitch = walk_pitch + int'($urandom_range(0, 6)) - 3;
        if (walk_roll > 180) walk_roll = 180;
        if (walk_roll < -180) walk_roll = -180;
        if (walk_pitch > 30) walk_pitch = 30;
        if (walk_pitch < -30) walk_pitch = -30;
        push_pair(walk_roll, walk_pitch);
      end else begin
        push_pair(any_angle(), any_angle());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (rst_n);

    // reset settings: flat line with centre dot, repeat without erase,
    // steep rolls, line off screen twice for an empty item, angle extremes
    push_pair(0, 0);
    push_pair(0, 0);
    push_pair(20, 0);
    push_pair(-20, 0);
    push_pair(-7, 2);
    push_pair(0, 180);
    push_pair(0, 180);
    push_pair(180, 0);
    push_pair(-180, -180);
    push_pair(ANGLE_MAX, ANGLE_MAX);
    push_pair(-256, -256);
    push_pair(0, -4);
    wait_drained();

    // reversal of both angles, most negative angle saturates; no centre dot
    apply_settings(5, 1'b0, 1'b1, 1'b1);
    push_pair(-256, -256);
    push_pair(-256, 0);
    push_pair(0, -256);
    push_pair(12, -3);
    push_pair(0, 0);
    wait_drained();

    // large spacing: rows past 15 wrap
    apply_settings(7, 1'b1, 1'b0, 1'b1);
    push_pair(0, -40);
    push_pair(0, -48);
    push_pair(30, -50);
    push_pair(0, -56);
    push_pair(-256, 5);
    wait_drained();

    // random phases over a spread of settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_settings(4, 1'b1, 1'b0, 1'b0);
        1: apply_settings(5, 1'b0, 1'b1, 1'b0);
        2: apply_settings(4, 1'b0, 1'b0, 1'b1);
        3: apply_settings(5, 1'b1, 1'b1, 1'b1);
        4: apply_settings($urandom_range(0, 7), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 1));
        default: apply_settings($urandom_range(4, 5), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      if (ph == 2) calm <= 1'b1;
      if (ph == 3) hold_req <= 1'b1;
      queue_random_items(16);
      wait_drained();
      calm <= 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run: %0d angle items over %0d register settings", items_taken, settings_used);
    $display("run: %0d draws, %0d erases, %0d empty items, %0d mismatches",
             draws_seen, erases_seen, blank_items, fail_count);
    if (fail_count == 0 && cell_writes_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
